/* rtl/asm_pkg.sv */
// Shared codes, defaults and types for the attribute stack machine.
package asm_pkg;

  localparam int StackDepthDefault = 16;
  localparam int AttrCountDefault  = 16;

  localparam int CmdW    = 3;
  localparam int IdxW    = 4;
  localparam int ValW    = 32;
  localparam int StatusW = 2;

  localparam logic [CmdW-1:0] CmdSet    = 3'd0;
  localparam logic [CmdW-1:0] CmdLoad   = 3'd1;
  localparam logic [CmdW-1:0] CmdStore  = 3'd2;
  localparam logic [CmdW-1:0] CmdUnary  = 3'd3;
  localparam logic [CmdW-1:0] CmdBinary = 3'd4;
  localparam logic [CmdW-1:0] CmdRead   = 3'd5;

  localparam logic [StatusW-1:0] StatusOk        = 2'd0;
  localparam logic [StatusW-1:0] StatusUnderflow = 2'd1;
  localparam logic [StatusW-1:0] StatusOverflow  = 2'd2;

  typedef struct packed {
    logic [CmdW-1:0] command;
    logic            op_select;
  } asm_op_t;

endpackage

/* rtl/asm_if.sv */
// Instruction and result channel interfaces.
interface asm_cmd_if;
  import asm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CmdW-1:0]        command;
  logic [IdxW-1:0]        attr_index;
  logic                   op_select;
  logic signed [ValW-1:0] set_value;
  logic                   end_of_program;

  modport source (output valid, command, attr_index, op_select, set_value, end_of_program,
                  input ready);
  modport sink (input valid, command, attr_index, op_select, set_value, end_of_program,
                output ready);
endinterface

interface asm_res_if;
  import asm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [IdxW-1:0]        out_index;
  logic signed [ValW-1:0] out_value;
  logic                   value_valid;
  logic [StatusW-1:0]     status;

  modport source (output valid, out_index, out_value, value_valid, status, input ready);
  modport sink (input valid, out_index, out_value, value_valid, status, output ready);
endinterface

/* rtl/attribute_stack_machine.sv */
// Attribute stack machine: postfix evaluator over an attribute register file.
// Channels: cmd_i takes one instruction per transfer (set, load, store, unary,
// binary, read, plus an end-of-program mark); res_o gives exactly one result
// per instruction, in order: slot, value, value_valid and status.
// Throughput is one instruction per cycle once the clearing pass is done and
// while res_o.ready stays high. An instruction is issued in the cycle of its
// transfer, which reads the attribute RAM and the stack RAM; the execute stage
// then runs it, does its RAM write-back and loads the output register.
// The top of stack lives in a register; back-to-back hits on the same RAM
// entry are forwarded from the executing instruction.
// After reset the attribute RAM is cleared, one entry per cycle, so cmd_i.ready
// stays low until the last entry is cleared. The stack needs no clearing.
// When the receiver stalls, the output register holds its result, one more
// instruction waits in the execute stage, and then cmd_i.ready drops.
module attribute_stack_machine #(
  parameter int STACK_DEPTH = asm_pkg::StackDepthDefault,
  parameter int ATTR_COUNT  = asm_pkg::AttrCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  asm_cmd_if.sink     cmd_i,
  asm_res_if.source   res_o
);
  import asm_pkg::*;

  localparam int StkAw  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CntW   = $clog2(STACK_DEPTH + 1);
  localparam int AttrAw = (ATTR_COUNT > 1) ? $clog2(ATTR_COUNT) : 1;

  // clearing pass
  logic              clr_active_q;
  logic [AttrAw-1:0] clr_addr_q;

  // issue side
  logic              accept;
  logic [CntW-1:0]   count_q, count_d;
  logic [StatusW-1:0] status_d;
  logic              idx_ok;
  logic [StkAw-1:0]  stk_raddr;
  logic [StkAw-1:0]  stk_waddr_d;

  // execute stage
  logic                   s2_valid_q;
  logic [CmdW-1:0]        s2_cmd_q;
  logic [IdxW-1:0]        s2_idx_q;
  logic                   s2_sel_q;
  logic signed [ValW-1:0] s2_setv_q;
  logic [StatusW-1:0]     s2_status_q;
  logic                   s2_idx_ok_q;
  logic [StkAw-1:0]       s2_waddr_q;
  logic                   s2_fire;

  logic                   fwd_stk_q, fwd_attr_q;
  logic signed [ValW-1:0] fwd_stk_data_q, fwd_attr_data_q;

  logic signed [ValW-1:0] tos_q, tos_d;
  logic                   tos_we;

  logic [ValW-1:0]        stk_rdata, attr_rdata;
  logic signed [ValW-1:0] attr_val, next_val, alu_res;
  asm_op_t                alu_op;

  logic                   stk_we;
  logic signed [ValW-1:0] stk_wdata;
  logic                   attr_we;
  logic signed [ValW-1:0] attr_wdata;
  logic                   ram_attr_we;
  logic [AttrAw-1:0]      ram_attr_waddr;
  logic [ValW-1:0]        ram_attr_wdata;

  logic                   res_valid_d;
  logic [IdxW-1:0]        res_idx_d;
  logic signed [ValW-1:0] res_val_d;

  logic                   out_valid_q;
  logic [IdxW-1:0]        out_idx_q;
  logic signed [ValW-1:0] out_val_q;
  logic                   out_vv_q;
  logic [StatusW-1:0]     out_status_q;

  // ---------------- issue ----------------
  assign s2_fire      = s2_valid_q && (!out_valid_q || res_o.ready);
  assign cmd_i.ready  = !clr_active_q && (!s2_valid_q || s2_fire);
  assign accept       = cmd_i.valid && cmd_i.ready;
  assign idx_ok       = (32'(cmd_i.attr_index) < ATTR_COUNT);
  assign stk_raddr    = StkAw'(count_q - CntW'(2));

  always_comb begin
    status_d    = StatusOk;
    count_d     = count_q;
    stk_waddr_d = StkAw'(count_q);
    unique case (cmd_i.command)
      CmdLoad: begin
        if (32'(count_q) >= STACK_DEPTH) begin
          status_d = StatusOverflow;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      CmdStore: begin
        if (count_q == '0) begin
          status_d = StatusUnderflow;
        end else begin
          count_d = count_q - CntW'(1);
        end
      end
      CmdUnary: begin
        stk_waddr_d = StkAw'(count_q - CntW'(1));
        if (count_q == '0) begin
          status_d = StatusUnderflow;
        end
      end
      CmdBinary: begin
        stk_waddr_d = StkAw'(count_q - CntW'(2));
        if (count_q < CntW'(2)) begin
          status_d = StatusUnderflow;
        end else begin
          count_d = count_q - CntW'(1);
        end
      end
      default: begin
      end
    endcase
    if (cmd_i.end_of_program) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      count_q      <= '0;
      s2_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (clr_active_q) begin
        clr_addr_q <= clr_addr_q + AttrAw'(1);
        if (clr_addr_q == AttrAw'(ATTR_COUNT - 1)) begin
          clr_active_q <= 1'b0;
        end
      end
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        s2_valid_q <= 1'b1;
      end else if (s2_fire) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_fire) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_cmd_q    <= cmd_i.command;
      s2_idx_q    <= cmd_i.attr_index;
      s2_sel_q    <= cmd_i.op_select;
      s2_setv_q   <= cmd_i.set_value;
      s2_status_q <= status_d;
      s2_idx_ok_q <= idx_ok;
      s2_waddr_q  <= stk_waddr_d;
      // catch writes that land on the entries read in this same cycle
      fwd_stk_q       <= s2_fire && stk_we && (s2_waddr_q == stk_raddr);
      fwd_stk_data_q  <= stk_wdata;
      fwd_attr_q      <= s2_fire && attr_we && (s2_idx_q == cmd_i.attr_index);
      fwd_attr_data_q <= attr_wdata;
    end
    if (s2_fire && tos_we) begin
      tos_q <= tos_d;
    end
    if (s2_fire) begin
      out_idx_q    <= res_idx_d;
      out_val_q    <= res_val_d;
      out_vv_q     <= res_valid_d;
      out_status_q <= s2_status_q;
    end
  end

  // ---------------- memories ----------------
  assign ram_attr_we    = clr_active_q || (s2_fire && attr_we);
  assign ram_attr_waddr = clr_active_q ? clr_addr_q : AttrAw'(s2_idx_q);
  assign ram_attr_wdata = clr_active_q ? '0 : attr_wdata;

  asm_ram #(
    .WIDTH (ValW),
    .DEPTH (ATTR_COUNT)
  ) u_attr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_attr_we),
    .waddr_i (ram_attr_waddr),
    .wdata_i (ram_attr_wdata),
    .re_i    (accept),
    .raddr_i (AttrAw'(cmd_i.attr_index)),
    .rdata_o (attr_rdata)
  );

  asm_ram #(
    .WIDTH (ValW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (s2_fire && stk_we),
    .waddr_i (s2_waddr_q),
    .wdata_i (stk_wdata),
    .re_i    (accept),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // ---------------- execute ----------------
  assign attr_val = !s2_idx_ok_q ? '0 : (fwd_attr_q ? fwd_attr_data_q : attr_rdata);
  assign next_val = fwd_stk_q ? fwd_stk_data_q : stk_rdata;
  assign alu_op   = '{command: s2_cmd_q, op_select: s2_sel_q};

  asm_alu u_alu (
    .op_i     (alu_op),
    .tos_i    (tos_q),
    .next_i   (next_val),
    .result_o (alu_res)
  );

  always_comb begin
    stk_we      = 1'b0;
    stk_wdata   = alu_res;
    attr_we     = 1'b0;
    attr_wdata  = tos_q;
    tos_we      = 1'b0;
    tos_d       = alu_res;
    res_valid_d = 1'b0;
    res_idx_d   = '0;
    res_val_d   = '0;
    unique case (s2_cmd_q)
      CmdSet: begin
        attr_we    = s2_idx_ok_q;
        attr_wdata = s2_setv_q;
      end
      CmdLoad: begin
        if (s2_status_q == StatusOk) begin
          stk_we    = 1'b1;
          stk_wdata = attr_val;
          tos_we    = 1'b1;
          tos_d     = attr_val;
        end
      end
      CmdStore: begin
        if (s2_status_q == StatusOk) begin
          attr_we     = s2_idx_ok_q;
          tos_we      = 1'b1;
          tos_d       = next_val;
          res_valid_d = 1'b1;
          res_idx_d   = s2_idx_q;
          res_val_d   = tos_q;
        end
      end
      CmdUnary: begin
        // copy leaves the stack as it is
        if (s2_status_q == StatusOk && s2_sel_q) begin
          stk_we = 1'b1;
          tos_we = 1'b1;
        end
      end
      CmdBinary: begin
        if (s2_status_q == StatusOk) begin
          stk_we = 1'b1;
          tos_we = 1'b1;
        end
      end
      CmdRead: begin
        res_valid_d = 1'b1;
        res_idx_d   = s2_idx_q;
        res_val_d   = attr_val;
      end
      default: begin
      end
    endcase
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.out_index   = out_idx_q;
  assign res_o.out_value   = out_val_q;
  assign res_o.value_valid = out_vv_q;
  assign res_o.status      = out_status_q;

endmodule

/* rtl/asm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module asm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read returns the old contents on a same-address write
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/asm_alu.sv */
// Saturating Q16.16 negate, add and subtract on the top of stack.
module asm_alu (
  input  asm_pkg::asm_op_t               op_i,
  input  logic signed [asm_pkg::ValW-1:0] tos_i,
  input  logic signed [asm_pkg::ValW-1:0] next_i,
  output logic signed [asm_pkg::ValW-1:0] result_o
);
  import asm_pkg::*;

  localparam logic signed [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic signed [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};

  logic signed [ValW:0] tos_x;
  logic signed [ValW:0] next_x;
  logic signed [ValW:0] wide;

  assign tos_x  = {tos_i[ValW-1], tos_i};
  assign next_x = {next_i[ValW-1], next_i};

  always_comb begin
    if (op_i.command == CmdBinary) begin
      wide = op_i.op_select ? (tos_x - next_x) : (tos_x + next_x);
    end else begin
      wide = (ValW+1)'(0) - tos_x;
    end
    // clamp when the two top bits disagree
    if (wide[ValW] != wide[ValW-1]) begin
      result_o = wide[ValW] ? ValMin : ValMax;
    end else begin
      result_o = wide[ValW-1:0];
    end
  end

endmodule
